// File: design/met_pkg.sv
package met_pkg;
  localparam int DEF_MATRIX_SIZE   = 3;
  localparam int DEF_FRACTION_BITS = 48;
  localparam int WORD_W  = 64;
  localparam int TOL_W   = 63;
  localparam int TERM_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [TOL_W-1:0]  TOL_RESET   = 63'd792281625;
  localparam logic [TERM_W-1:0] LIMIT_RESET = 7'd127;

  typedef enum logic [0:0] {
    REG_TOLERANCE  = 1'b0,
    REG_TERM_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_NORM, S_CHECK, S_MAC, S_ROUND, S_DIV, S_STORE, S_UPDATE,
    S_EMIT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

// File: design/met_stream_if.sv
interface met_stream_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/met_ram.sv
module met_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/met_divider.sv
// unsigned restoring divider, one quotient bit per cycle
module met_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  met_pkg::div_ctl_t           ctl,
  input  logic [met_pkg::WORD_W-1:0]  dividend,
  input  logic [met_pkg::TERM_W-1:0]  divisor,
  output met_pkg::div_sts_t           sts,
  output logic [met_pkg::WORD_W-1:0]  quotient
);
  localparam int W = met_pkg::WORD_W;
  localparam int DW = met_pkg::TERM_W;

  logic [W-1:0]        q_r, q_nxt;
  logic [DW:0]         rem_r, rem_nxt;
  logic [DW-1:0]       dvs_r, dvs_nxt;
  logic [$clog2(W):0]  cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [DW+1:0]       trial;
  logic [DW+1:0]       shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, q_r[W-1]};
    trial    = shifted - {2'b00, dvs_r};
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(W)+1)'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;
endmodule

// File: design/matrix_exponential_taylor.sv
// matrix exponential by taylor series, signed fixed point in 64-bit words
// in_ channel: the N*N elements of A in row-major order, one per transfer;
//   the block takes elements while loading and drops in_ready from the
//   transfer of the last element until the result has been sent
// out_ channel: N*N result transfers in row-major order, last_element high
//   on the final one; status and terms_used repeat on every transfer
// cfg_ port: index 0 tolerance_squared, index 1 term_limit; the user must
//   write it only while the block is idle, which the block does not enforce
// datapath: one shared 32x32 multiplier builds each 64x64 product from four
//   partials, after the ram read and the operand latch, and also squares
//   term elements for the norm; a bit-serial divider takes the division by
//   the round number
// identity setup and first norm follow the last element; results go out one
//   at a time, each read from the sum ram after the previous transfer
// one matrix at a time: the next load starts after the last result transfer
// reset: control and configuration registers go to their reset values, load
//   count clears, block waits for the first element
// a stalled receiver holds the current result; nothing advances until the
//   transfer happens
module matrix_exponential_taylor #(
  parameter int MATRIX_SIZE   = met_pkg::DEF_MATRIX_SIZE,
  parameter int FRACTION_BITS = met_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  met_stream_if.sink                      in_ch,
  met_stream_if.source                    out_ch,
  output logic                            out_last_element,
  output logic [1:0]                      out_status,
  output logic [met_pkg::TERM_W-1:0]      out_terms_used,
  input  logic                            cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [met_pkg::TOL_W-1:0]       cfg_data
);
  localparam int W     = met_pkg::WORD_W;
  localparam int TW    = met_pkg::TERM_W;
  localparam int N     = MATRIX_SIZE;
  localparam int CELLS = N * N;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(N);
  localparam int FB    = FRACTION_BITS;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE     = W'(1) << FB;

  // configuration registers
  logic [met_pkg::TOL_W-1:0] tol_r;
  logic [TW-1:0]             limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= met_pkg::TOL_RESET;
      limit_r <= met_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (met_pkg::cfg_reg_t'(cfg_index))
        met_pkg::REG_TOLERANCE:  tol_r   <= cfg_data;
        met_pkg::REG_TERM_LIMIT: limit_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  met_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   cell_r, cell_nxt;      // matrix element pointer
  logic [NW-1:0]   k_r, k_nxt;            // inner product index
  logic [1:0]      part_r, part_nxt;      // partial product index
  logic            op_vld_r, op_vld_nxt;  // multiplier operands latched
  logic [TW-1:0]   terms_r, terms_nxt;
  logic            sat_r, sat_nxt;
  logic            norm_big_r, norm_big_nxt;
  logic            rd_pend_r, rd_pend_nxt; // ram read in flight
  logic [1:0]      status_r, status_nxt;

  // datapath registers
  logic [191:0]    acc_r, acc_nxt;
  logic [W-1:0]    opa_r, opa_nxt, opb_r, opb_nxt;
  logic            neg_r, neg_nxt;
  logic [63:0]     pp_r, pp_nxt;           // registered partial product
  logic            pp_vld_r, pp_vld_nxt;
  logic [1:0]      pp_part_r, pp_part_nxt;
  logic [W-1:0]    v_r, v_nxt;             // floored product
  logic [W:0]      norm_r, norm_nxt;       // saturating norm with 1 spare bit

  // rams: input, term, next term, sum
  logic          a_we, t_we, x_we, s_we;
  logic [AW-1:0] a_wa, a_ra, t_wa, t_ra, x_wa, x_ra, s_wa, s_ra;
  logic [W-1:0]  a_wd, a_rd, t_wd, t_rd, x_wd, x_rd, s_wd, s_rd;

  met_ram #(.WIDTH(W), .DEPTH(CELLS)) u_a_ram (.clk, .we(a_we), .waddr(a_wa),
    .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  met_ram #(.WIDTH(W), .DEPTH(CELLS)) u_t_ram (.clk, .we(t_we), .waddr(t_wa),
    .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  met_ram #(.WIDTH(W), .DEPTH(CELLS)) u_x_ram (.clk, .we(x_we), .waddr(x_wa),
    .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
  met_ram #(.WIDTH(W), .DEPTH(CELLS)) u_s_ram (.clk, .we(s_we), .waddr(s_wa),
    .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  // divider
  met_pkg::div_ctl_t div_ctl;
  met_pkg::div_sts_t div_sts;
  logic [W-1:0]      div_dividend, div_q;

  met_divider u_div (.clk, .rst_n, .ctl(div_ctl), .dividend(div_dividend),
    .divisor(terms_r), .sts(div_sts), .quotient(div_q));

  // row/col of current cell
  logic [NW-1:0] row_r, col_r, row_nxt, col_nxt;

  // helper combinational values
  logic [W-1:0]  mag_t, mag_a, mag_v;
  logic [31:0]   mul_x, mul_y;
  logic [63:0]   mul_p;
  logic [191:0]  pp_shift, pp_signed;
  logic [191:0]  acc_fl;
  logic [W-1:0]  sum_add;
  logic          add_ovf;
  logic [W:0]    norm_add;
  logic          last_cell;

  assign mag_t = t_rd[W-1] ? -t_rd : t_rd;
  assign mag_a = a_rd[W-1] ? -a_rd : a_rd;
  assign mag_v = v_r[W-1] ? -v_r : v_r;
  // shared multiplier: squares term elements during the norm pass
  assign mul_x = (state_r == met_pkg::S_NORM) ? mag_t[31:0] :
                 (part_r[0] ? opa_r[63:32] : opa_r[31:0]);
  assign mul_y = (state_r == met_pkg::S_NORM) ? mag_t[31:0] :
                 (part_r[1] ? opb_r[63:32] : opb_r[31:0]);
  assign mul_p = 64'(mul_x) * 64'(mul_y);
  assign pp_shift = 192'(pp_r) << (32 * (int'(pp_part_r[0]) + int'(pp_part_r[1])));
  assign pp_signed = neg_r ? -pp_shift : pp_shift;
  assign acc_fl = 192'($signed(acc_r) >>> FB);
  assign sum_add = s_rd + x_rd;
  assign add_ovf = (s_rd[W-1] == x_rd[W-1]) && (sum_add[W-1] != s_rd[W-1]);
  assign norm_add = norm_r + {1'b0, mul_p};
  assign last_cell = (cell_r == AW'(CELLS - 1));
  assign div_dividend = mag_v;

  always_comb begin
    state_nxt    = state_r;
    cell_nxt     = cell_r;
    k_nxt        = k_r;
    part_nxt     = part_r;
    op_vld_nxt   = op_vld_r;
    terms_nxt    = terms_r;
    sat_nxt      = sat_r;
    norm_big_nxt = norm_big_r;
    rd_pend_nxt  = 1'b0;
    status_nxt   = status_r;
    acc_nxt      = acc_r;
    opa_nxt      = opa_r;
    opb_nxt      = opb_r;
    neg_nxt      = neg_r;
    pp_nxt       = mul_p;
    pp_vld_nxt   = 1'b0;
    pp_part_nxt  = part_r;
    v_nxt        = v_r;
    norm_nxt     = norm_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    a_we = 1'b0; a_wa = cell_r; a_wd = in_ch.data; a_ra = cell_r;
    t_we = 1'b0; t_wa = cell_r; t_wd = '0;        t_ra = cell_r;
    x_we = 1'b0; x_wa = cell_r; x_wd = '0;        x_ra = cell_r;
    s_we = 1'b0; s_wa = cell_r; s_wd = '0;        s_ra = cell_r;
    div_ctl.start = 1'b0;
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;

    unique case (state_r)
      met_pkg::S_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          a_we = 1'b1;
          if (last_cell) begin
            cell_nxt  = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            terms_nxt = '0;
            sat_nxt   = 1'b0;
            state_nxt = met_pkg::S_INIT;
          end else begin
            cell_nxt = cell_r + 1'b1;
          end
        end
      end
      met_pkg::S_INIT: begin
        t_we = 1'b1;
        s_we = 1'b1;
        t_wd = (row_r == col_r) ? ONE : '0;
        s_wd = t_wd;
        cell_nxt = cell_r + 1'b1;
        if (col_r == NW'(N - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (last_cell) begin
          cell_nxt     = '0;
          norm_nxt     = '0;
          norm_big_nxt = 1'b0;
          rd_pend_nxt  = 1'b0;
          state_nxt    = met_pkg::S_NORM;
        end
      end
      met_pkg::S_NORM: begin
        // each term element: issue read, then accumulate
        t_ra = cell_r;
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          if (mag_t[W-1:32] != '0) begin
            norm_big_nxt = 1'b1;
          end
          norm_nxt = norm_add[W] ? {1'b1, {W{1'b1}}} : norm_add;
          if (norm_r[W]) begin
            norm_nxt = norm_r;
          end
          if (last_cell) begin
            cell_nxt  = '0;
            state_nxt = met_pkg::S_CHECK;
          end else begin
            cell_nxt = cell_r + 1'b1;
          end
        end
      end
      met_pkg::S_CHECK: begin
        row_nxt = '0;
        col_nxt = '0;
        k_nxt   = '0;
        if (!norm_big_r && !norm_r[W] && norm_r[W-1:0] <= {1'b0, tol_r}) begin
          status_nxt = sat_r ? met_pkg::ST_SATURATED : met_pkg::ST_CONVERGED;
          state_nxt  = met_pkg::S_EMIT;
        end else if (terms_r >= limit_r) begin
          status_nxt = sat_r ? met_pkg::ST_SATURATED : met_pkg::ST_LIMIT;
          state_nxt  = met_pkg::S_EMIT;
        end else begin
          terms_nxt   = terms_r + 1'b1;
          acc_nxt     = '0;
          part_nxt    = '0;
          op_vld_nxt  = 1'b0;
          rd_pend_nxt = 1'b0;
          state_nxt   = met_pkg::S_MAC;
        end
        cell_nxt = '0;
      end
      met_pkg::S_MAC: begin
        // term[row][k] * a[k][col]: read, latch magnitudes, four 32x32 partials
        t_ra = AW'(int'(row_r) * N + int'(k_r));
        a_ra = AW'(int'(k_r) * N + int'(col_r));
        if (pp_vld_r) begin
          acc_nxt = acc_r + pp_signed;
        end
        rd_pend_nxt = 1'b1;
        if (!rd_pend_r) begin
          part_nxt = '0;
        end else if (!op_vld_r) begin
          opa_nxt    = mag_t;
          opb_nxt    = mag_a;
          neg_nxt    = t_rd[W-1] ^ a_rd[W-1];
          op_vld_nxt = 1'b1;
          part_nxt   = '0;
        end else begin
          pp_vld_nxt  = 1'b1;
          pp_part_nxt = part_r;
          part_nxt    = part_r + 1'b1;
          if (part_r == 2'd3) begin
            // last partial for this k issued, it lands next cycle
            rd_pend_nxt = 1'b0;
            op_vld_nxt  = 1'b0;
            if (k_r == NW'(N - 1)) begin
              state_nxt = met_pkg::S_ROUND;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        end
      end
      met_pkg::S_ROUND: begin
        if (pp_vld_r) begin
          // fold in the last partial first
          acc_nxt = acc_r + pp_signed;
        end else begin
          if (acc_fl[191:63] == '0 || acc_fl[191:63] == '1) begin
            v_nxt = acc_fl[W-1:0];
          end else begin
            v_nxt   = acc_r[191] ? NEG_MIN : POS_MAX;
            sat_nxt = 1'b1;
          end
          state_nxt = met_pkg::S_DIV;
        end
      end
      met_pkg::S_DIV: begin
        if (!div_sts.busy && !div_sts.done && !rd_pend_r) begin
          div_ctl.start = 1'b1;
          rd_pend_nxt   = 1'b1;
        end else begin
          rd_pend_nxt = 1'b1;
        end
        if (div_sts.done) begin
          rd_pend_nxt = 1'b0;
          state_nxt   = met_pkg::S_STORE;
        end
      end
      met_pkg::S_STORE: begin
        x_we = 1'b1;
        x_wa = AW'(int'(row_r) * N + int'(col_r));
        x_wd = v_r[W-1] ? -div_q : div_q;
        acc_nxt = '0;
        k_nxt   = '0;
        state_nxt = met_pkg::S_MAC;
        if (col_r == NW'(N - 1)) begin
          col_nxt = '0;
          if (row_r == NW'(N - 1)) begin
            row_nxt   = '0;
            cell_nxt  = '0;
            state_nxt = met_pkg::S_UPDATE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      met_pkg::S_UPDATE: begin
        // copy next term into term, add into sum
        x_ra = cell_r;
        s_ra = cell_r;
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          t_we = 1'b1;
          t_wd = x_rd;
          s_we = 1'b1;
          s_wd = add_ovf ? (s_rd[W-1] ? NEG_MIN : POS_MAX) : sum_add;
          if (add_ovf) begin
            sat_nxt = 1'b1;
          end
          if (last_cell) begin
            cell_nxt     = '0;
            norm_nxt     = '0;
            norm_big_nxt = 1'b0;
            state_nxt    = met_pkg::S_NORM;
          end else begin
            cell_nxt = cell_r + 1'b1;
          end
        end
      end
      met_pkg::S_EMIT: begin
        s_ra = cell_r;
        if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt  = 1'b1;
          out_ch.valid = 1'b1;
          if (out_ch.ready) begin
            rd_pend_nxt = 1'b0;
            if (last_cell) begin
              cell_nxt  = '0;
              state_nxt = met_pkg::S_LOAD;
            end else begin
              cell_nxt = cell_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = met_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= met_pkg::S_LOAD;
      cell_r     <= '0;
      k_r        <= '0;
      part_r     <= '0;
      op_vld_r   <= 1'b0;
      terms_r    <= '0;
      sat_r      <= 1'b0;
      norm_big_r <= 1'b0;
      rd_pend_r  <= 1'b0;
      status_r   <= '0;
      pp_vld_r   <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      cell_r     <= cell_nxt;
      k_r        <= k_nxt;
      part_r     <= part_nxt;
      op_vld_r   <= op_vld_nxt;
      terms_r    <= terms_nxt;
      sat_r      <= sat_nxt;
      norm_big_r <= norm_big_nxt;
      rd_pend_r  <= rd_pend_nxt;
      status_r   <= status_nxt;
      pp_vld_r   <= pp_vld_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
    acc_r     <= acc_nxt;
    opa_r     <= opa_nxt;
    opb_r     <= opb_nxt;
    neg_r     <= neg_nxt;
    pp_r      <= pp_nxt;
    pp_part_r <= pp_part_nxt;
    v_r       <= v_nxt;
    norm_r    <= norm_nxt;
  end

  // result channel: sum ram read data held while the receiver stalls
  assign out_ch.data      = s_rd;
  assign out_last_element = last_cell;
  assign out_status       = status_r;
  assign out_terms_used   = terms_r;

  // assertions
  a_no_ready_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted while results pending");
  a_terms_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_terms_used <= limit_r)
    else $error("terms exceed limit");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_status != 2'd3)
    else $error("bad status code");
endmodule

// File: tb/met_tb_pkg.sv
package met_tb_pkg;
  import met_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] element;
    logic              last;
    status_t           status;
    logic [TERM_W-1:0] terms;
  } result_item_t;
endpackage

// File: tb/tb.sv
module tb;
  import met_pkg::*;
  import met_tb_pkg::*;

  localparam int N     = DEF_MATRIX_SIZE;
  localparam int CELLS = N * N;
  localparam int FB    = DEF_FRACTION_BITS;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0] cfg_data = '0;
  logic out_last_element;
  logic [1:0] out_status;
  logic [TERM_W-1:0] out_terms_used;

  met_stream_if #(.W(WORD_W)) in_if ();
  met_stream_if #(.W(WORD_W)) out_if ();

  matrix_exponential_taylor #(.MATRIX_SIZE(N), .FRACTION_BITS(FB)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .out_last_element(out_last_element),
    .out_status(out_status),
    .out_terms_used(out_terms_used),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of the registers
  logic [TOL_W-1:0]  tol_sq = TOL_RESET;
  logic [TERM_W-1:0] term_lim = LIMIT_RESET;

  logic [63:0]  pending_elems[$];
  result_item_t expected_results[$];
  logic [63:0]  loaded[CELLS];
  int load_idx = 0;
  int errors = 0;

  // stimulus control, written by the sequencer only
  bit tx_pause = 1'b0;
  bit no_idle = 1'b0;
  int rx_long_token = 0;

  int in_acc_cnt = 0;
  int idle_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch: %s got %h expected %h", what, got, want);
  endtask

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  // saturating add of two words, flags overflow
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          inout bit sat);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? NEG_MIN : POS_MAX;
    end
    return s;
  endfunction

  function automatic bit norm_ok(input logic [63:0] t[CELLS]);
    logic [64:0] norm;
    logic [63:0] m;
    norm = '0;
    for (int i = 0; i < CELLS; i++) begin
      m = mag(t[i]);
      if (m[63:32] != 0) return 1'b0;
      norm = norm + (m * m);
      if (norm[64]) norm = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return norm[63:0] <= {1'b0, tol_sq};
  endfunction

  // series expansion of exp(A) for the loaded matrix, queues the N*N results
  function automatic void taylor_expm();
    logic [63:0] term[CELLS];
    logic [63:0] total[CELLS];
    logic [63:0] nxt[CELLS];
    logic signed [191:0] acc;
    logic signed [127:0] prod;
    logic signed [191:0] fl;
    logic [63:0] v, q;
    bit sat;
    int rounds;
    status_t st;
    result_item_t r;
    sat = 1'b0;
    rounds = 0;
    for (int i = 0; i < CELLS; i++) begin
      term[i] = (i / N == i % N) ? (64'd1 << FB) : 64'd0;
      total[i] = term[i];
    end
    forever begin
      if (norm_ok(term)) begin
        st = ST_CONVERGED;
        break;
      end
      if (rounds >= term_lim) begin
        st = ST_LIMIT;
        break;
      end
      rounds++;
      for (int rr = 0; rr < N; rr++) begin
        for (int cc = 0; cc < N; cc++) begin
          acc = '0;
          for (int k = 0; k < N; k++) begin
            prod = $signed(term[rr*N+k]) * $signed(loaded[k*N+cc]);
            acc = acc + prod;
          end
          fl = acc >>> FB;
          // floor then clamp to the signed word range
          if (fl[191:63] == '0 || fl[191:63] == '1) begin
            v = fl[63:0];
          end else begin
            sat = 1'b1;
            v = fl[191] ? NEG_MIN : POS_MAX;
          end
          q = mag(v) / 64'(rounds);
          nxt[rr*N+cc] = v[63] ? -q : q;
        end
      end
      for (int i = 0; i < CELLS; i++) begin
        term[i] = nxt[i];
        total[i] = sat_add(total[i], nxt[i], sat);
      end
    end
    if (sat) st = ST_SATURATED;
    for (int i = 0; i < CELLS; i++) begin
      r.element = total[i];
      r.last = (i == CELLS - 1);
      r.status = st;
      r.terms = TERM_W'(rounds);
      expected_results.push_back(r);
    end
  endfunction

  // input side: collect accepted elements, predict on the last one
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      in_acc_cnt++;
      void'(pending_elems.pop_front());
      loaded[load_idx] = in_if.data;
      load_idx++;
      if (load_idx == CELLS) begin
        load_idx = 0;
        taylor_expm();
      end
    end
  end

  // result side: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    result_item_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_if.data, 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (out_if.data !== e.element) report("result_element", out_if.data, e.element);
        if (out_last_element !== e.last)
          report("last_element", 64'(out_last_element), 64'(e.last));
        if (out_status !== e.status)
          report("status", 64'(out_status), 64'(e.status));
        if (out_terms_used !== e.terms)
          report("terms_used", 64'(out_terms_used), 64'(e.terms));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // driver: offers the front of the pending queue, holds it until transfer
  int drv_seen = 0;
  int tx_gap = 0;
  always @(negedge clk) begin
    if (in_if.valid && in_acc_cnt == drv_seen) begin
      // still waiting for the transfer, keep the item up
    end else begin
      drv_seen = in_acc_cnt;
      if (tx_gap > 0) begin
        tx_gap--;
        in_if.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        tx_gap = $urandom_range(1, 18) - 1;
        in_if.valid <= 1'b0;
      end else if (!tx_pause && pending_elems.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_elems[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  int rx_gap = 0;
  int rx_long_seen = 0;
  always @(negedge clk) begin
    if (rx_long_token != rx_long_seen) begin
      rx_long_seen = rx_long_token;
      rx_gap = 3000;
    end
    if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 18) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[TOL_W-1:0];
    if (idx == REG_TOLERANCE) tol_sq = value[TOL_W-1:0];
    else term_lim = value[TERM_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // everything sent and every result back, then a short settle
  task automatic drain();
    wait (pending_elems.size() == 0 && load_idx == 0 && expected_results.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // element source: 0 small, 1 full range, 2 zero, 3 max, 4 min
  function automatic logic [63:0] pick_elem(input int mode);
    logic [63:0] v;
    case (mode)
      0: begin
        v = {$urandom, $urandom} >> $urandom_range(18, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      1: v = {$urandom, $urandom};
      2: v = '0;
      3: v = POS_MAX;
      default: v = NEG_MIN;
    endcase
    return v;
  endfunction

  task automatic queue_matrix(input int mode);
    for (int i = 0; i < CELLS; i++) begin
      pending_elems.push_back(pick_elem(mode));
    end
  endtask

  initial begin
    logic [63:0] tv;
    int lim;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero matrix, small matrices
    queue_matrix(2);
    queue_matrix(0);
    queue_matrix(0);
    drain();

    // term limit zero: no round runs
    write_reg(REG_TERM_LIMIT, 64'd0);
    queue_matrix(0);
    drain();

    // extremes under a short limit and zero tolerance, saturation expected
    write_reg(REG_TERM_LIMIT, 64'd2);
    write_reg(REG_TOLERANCE, 64'd0);
    queue_matrix(3);
    queue_matrix(4);
    queue_matrix(1);
    drain();

    // widest tolerance, longest limit
    write_reg(REG_TOLERANCE, {1'b0, {63{1'b1}}});
    write_reg(REG_TERM_LIMIT, 64'd127);
    queue_matrix(0);
    drain();

    // random groups of matrices with random settings
    for (int g = 0; g < 8; g++) begin
      if (g >= 6) no_idle = 1'b1;
      lim = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 127);
      write_reg(REG_TERM_LIMIT, 64'(lim));
      case ($urandom_range(0, 3))
        0: tv = 64'(TOL_RESET);
        1: tv = {$urandom, $urandom} >> $urandom_range(1, 40);
        2: tv = '0;
        default: tv = {1'b0, {63{1'b1}}};
      endcase
      write_reg(REG_TOLERANCE, tv);
      if (g == 2) rx_long_token++;
      for (int m = 0; m < 4; m++) begin
        if (g == 3 && m == 1) begin
          // previous matrix fully taken, its results still outstanding
          wait (pending_elems.size() == 0);
          tx_pause = 1'b1;
        end
        // full-range content only where the limit keeps the run short
        if (lim <= 4 && $urandom_range(0, 1)) queue_matrix(1);
        else queue_matrix(0);
        if (g == 3 && m == 1) begin
          // hold the sender until the block has emitted everything
          wait (expected_results.size() == 0);
          tx_pause = 1'b0;
        end
      end
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: matrix_exponential_taylor.f
design/met_pkg.sv
design/met_stream_if.sv
design/met_ram.sv
design/met_divider.sv
design/matrix_exponential_taylor.sv
tb/met_tb_pkg.sv
tb/tb.sv
